@@ rtl/pta_pkg.sv @@
// shared types and constants for the presence table with aging
package pta_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;
    localparam logic [31:0] AGE_LIMIT_RESET = 32'd30000;
    localparam logic signed [31:0] NO_USER_ID = -32'sd1;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FOLD
    } pta_state_t;

    // best candidate seen so far
    typedef struct packed {
        logic               have;
        logic [31:0]        stamp;
        logic signed [31:0] id;
    } pta_best_t;

    // one entry (or the pending update) handed to the compare unit
    typedef struct packed {
        logic               scan;
        logic               ent_valid;
        logic [31:0]        ent_stamp;
        logic signed [31:0] ent_id;
    } pta_eval_req_t;

    typedef struct packed {
        logic keep;
        logic hit;
        logic better;
    } pta_eval_rsp_t;

endpackage

@@ rtl/pta_eval_unit.sv @@
// shared compare unit: age check, id match and current-user ranking for one entry
module pta_eval_unit (
    input  pta_pkg::pta_eval_req_t req,
    input  pta_pkg::pta_best_t     best,
    input  logic [31:0]            now_ms,
    input  logic [31:0]            age_limit,
    input  logic                   sighting,
    input  logic signed [31:0]     sighted_id,
    output pta_pkg::pta_eval_rsp_t rsp
);

    logic [31:0] age;
    logic        aged;
    logic        keep;
    logic        hit;
    logic        ranks_higher;

    assign age  = now_ms - req.ent_stamp;
    assign aged = req.scan && (age > age_limit);
    assign keep = req.ent_valid && !aged;
    // ids are unique in the table, so the matching entry is the one being refreshed
    assign hit  = req.scan && keep && sighting && (req.ent_id == sighted_id);

    always_comb begin
        ranks_higher = !best.have
                    || (req.ent_stamp > best.stamp)
                    || ((req.ent_stamp == best.stamp) && (req.ent_id < best.id));
    end

    assign rsp.keep   = keep;
    assign rsp.hit    = hit;
    assign rsp.better = keep && !hit && (req.ent_stamp != 32'd0) && ranks_higher;

endmodule

@@ rtl/presence_table_with_aging.sv @@
// top level: presence table with aging, sequenced scan over the entry memory
// requests: a new request is accepted only in idle, after the scan and fold of the last;
//   each scan reads the single-port entry memory once per entry through one compare unit
// reset: aresetn synchronous active low, clears all valid bits and the control state,
//   age limit returns to 30000 ms; no clearing pass is needed
module presence_table_with_aging #(
    parameter int unsigned TABLE_ENTRIES = pta_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration: age limit register
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_now_ms,
    input  logic               s_has_sighting,
    input  logic signed [31:0] s_sighted_id,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_current_valid,
    output logic signed [31:0] m_current_id,
    output logic [4:0]         m_entry_count,
    output logic               m_dropped_full
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

    // sequencer
    pta_pkg::pta_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;

    // entry memory and valid bits
    logic [31:0]         id_mem    [TABLE_ENTRIES];
    logic [31:0]         stamp_mem [TABLE_ENTRIES];
    logic                valid_reg [TABLE_ENTRIES];

    // read pipeline stage
    logic                rd_live_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [31:0]         rd_id_reg;
    logic [31:0]         rd_stamp_reg;

    // latched request
    logic [31:0]         now_reg;
    logic                sight_reg;
    logic signed [31:0]  sid_reg;

    // configuration
    logic [31:0]         age_limit_reg;

    // scan results
    pta_pkg::pta_best_t  best_reg;
    pta_pkg::pta_best_t  best_fin;
    logic                hit_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [CNT_W-1:0]    surv_reg;

    // result register
    logic                m_valid_reg;

    // control terms
    logic                accept;
    logic                scan_issue;
    logic                scan_done;
    logic                scan_eval;
    logic                fold_go;
    logic                do_update;
    logic                do_insert;
    logic [IDX_W-1:0]    wr_idx;
    logic [CNT_W-1:0]    count_fin;
    logic [31:0]         count_ext;

    pta_pkg::pta_eval_req_t eval_req;
    pta_pkg::pta_eval_rsp_t eval_rsp;

    assign accept     = s_valid && s_ready;
    assign scan_issue = (state_reg == pta_pkg::ST_SCAN) && (cnt_reg < CNT_LAST);
    // the last entry is evaluated in the cycle the counter reaches the end
    assign scan_done  = (state_reg == pta_pkg::ST_SCAN) && (cnt_reg == CNT_LAST);
    assign scan_eval  = (state_reg == pta_pkg::ST_SCAN) && rd_live_reg;
    // the fold waits until the result register is free
    assign fold_go    = (state_reg == pta_pkg::ST_FOLD) && (!m_valid_reg || m_ready);

    // refresh an existing entry, or take the lowest free slot
    assign do_update  = sight_reg && (hit_found_reg || free_found_reg);
    assign do_insert  = sight_reg && !hit_found_reg && free_found_reg;
    assign wr_idx     = hit_found_reg ? hit_idx_reg : free_idx_reg;

    // compare unit input: a scanned entry, or the pending update during the fold
    always_comb begin
        if (state_reg == pta_pkg::ST_FOLD) begin
            eval_req.scan      = 1'b0;
            eval_req.ent_valid = do_update;
            eval_req.ent_stamp = now_reg;
            eval_req.ent_id    = sid_reg;
        end else begin
            eval_req.scan      = 1'b1;
            eval_req.ent_valid = rd_live_reg && valid_reg[rd_idx_reg];
            eval_req.ent_stamp = rd_stamp_reg;
            eval_req.ent_id    = $signed(rd_id_reg);
        end
    end

    pta_eval_unit u_eval (
        .req        (eval_req),
        .best       (best_reg),
        .now_ms     (now_reg),
        .age_limit  (age_limit_reg),
        .sighting   (sight_reg),
        .sighted_id (sid_reg),
        .rsp        (eval_rsp)
    );

    // final ranking includes the refreshed or inserted entry
    always_comb begin
        if (eval_rsp.better) begin
            best_fin.have  = 1'b1;
            best_fin.stamp = now_reg;
            best_fin.id    = sid_reg;
        end else begin
            best_fin = best_reg;
        end
    end

    assign count_fin = surv_reg + CNT_W'(do_insert);
    assign count_ext = 32'(count_fin);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pta_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pta_pkg::ST_SCAN;
                end
            end
            pta_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = pta_pkg::ST_FOLD;
                end
            end
            pta_pkg::ST_FOLD: begin
                if (fold_go) begin
                    state_next = pta_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pta_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == pta_pkg::ST_IDLE);
        m_valid = m_valid_reg;
    end

    // control state, valid bits and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pta_pkg::ST_IDLE;
            cnt_reg        <= '0;
            rd_live_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            age_limit_reg  <= pta_pkg::AGE_LIMIT_RESET;
            best_reg       <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            surv_reg       <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                age_limit_reg <= cfg_wdata;
            end

            if (accept) begin
                cnt_reg        <= '0;
                rd_live_reg    <= 1'b0;
                best_reg       <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                surv_reg       <= '0;
            end

            if (state_reg == pta_pkg::ST_SCAN) begin
                rd_live_reg <= scan_issue;
                rd_idx_reg  <= cnt_reg[IDX_W-1:0];
                if (scan_issue) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end

            if (scan_eval) begin
                // aged out entries are dropped here
                if (!eval_rsp.keep) begin
                    valid_reg[rd_idx_reg] <= 1'b0;
                    if (!free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= rd_idx_reg;
                    end
                end else begin
                    surv_reg <= surv_reg + CNT_W'(1);
                end
                if (eval_rsp.hit && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= rd_idx_reg;
                end
                if (eval_rsp.better) begin
                    best_reg.have  <= 1'b1;
                    best_reg.stamp <= rd_stamp_reg;
                    best_reg.id    <= $signed(rd_id_reg);
                end
            end

            if (fold_go) begin
                m_valid_reg <= 1'b1;
                if (do_insert) begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // entry memory: one write in the fold, one registered read per scan cycle
    always_ff @(posedge aclk) begin
        if (fold_go && do_update) begin
            id_mem[wr_idx]    <= sid_reg;
            stamp_mem[wr_idx] <= now_reg;
        end
        if (scan_issue) begin
            rd_id_reg    <= id_mem[cnt_reg[IDX_W-1:0]];
            rd_stamp_reg <= stamp_mem[cnt_reg[IDX_W-1:0]];
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg   <= s_now_ms;
            sight_reg <= s_has_sighting;
            sid_reg   <= s_sighted_id;
        end
        if (fold_go) begin
            m_current_valid <= best_fin.have;
            m_current_id    <= best_fin.have ? best_fin.id : pta_pkg::NO_USER_ID;
            m_entry_count   <= count_ext[pta_pkg::COUNT_W-1:0];
            m_dropped_full  <= sight_reg && !hit_found_reg && !free_found_reg;
        end
    end

    // an accepted request always starts a scan
    a_accept_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == pta_pkg::ST_SCAN))
        else $error("accepted request did not start a scan");

    // no current user is reported with the reserved id
    a_none_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_current_valid) |-> (m_current_id == pta_pkg::NO_USER_ID))
        else $error("empty result carries an id");

    // a refused sighting means every slot is in use
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dropped_full)
            |-> (32'(m_entry_count) == (TABLE_ENTRIES & 32'd31)))
        else $error("sighting dropped while table not full");

    // the fold never runs while the scan counter is short of the end
    a_fold_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pta_pkg::ST_FOLD) |-> (cnt_reg == CNT_LAST) && !rd_live_reg)
        else $error("fold entered before the scan finished");

endmodule
